FILE: src/ltb_pkg.sv
`default_nettype none

package ltb_pkg;

   localparam int POS_W = 17;
   localparam int IDX_W = 12;
   localparam int CNT_W = 13;

   localparam logic [POS_W-1:0] TEXT_LIMIT = 17'd65536;
   localparam logic [CNT_W-1:0] LINE_LIMIT = 13'd4096;

   localparam logic [7:0] CH_CR = 8'h0D;
   localparam logic [7:0] CH_LF = 8'h0A;

   typedef enum logic [1:0] {
      CMD_BYTE  = 2'd0,
      CMD_END   = 2'd1,
      CMD_QUERY = 2'd2
   } cmd_type;

   // the one command code with no meaning
   localparam logic [1:0] CMD_UNUSED = 2'd3;

   typedef enum logic [1:0] {
      KIND_RECORD = 2'd0,
      KIND_ANSWER = 2'd1,
      KIND_REJECT = 2'd2
   } kind_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SECOND,
      ST_QUERY
   } ltb_state_type;

   typedef enum logic [1:0] {
      SR_IDLE,
      SR_STEP,
      SR_CMP,
      SR_FIN
   } srch_state_type;

   typedef struct packed {
      logic             en;
      logic [IDX_W-1:0] addr;
      logic [POS_W-1:0] data;
   } tbl_wr_type;

   typedef struct packed {
      logic             start;
      logic [CNT_W-1:0] count;
      logic [15:0]      offset;
   } srch_req_type;

   typedef struct packed {
      logic             valid;
      logic [IDX_W-1:0] index;
      logic [POS_W-1:0] start_pos;
   } srch_rsp_type;

endpackage

`default_nettype wire

FILE: src/ltb_store.sv
`default_nettype none

module ltb_store (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire ltb_pkg::tbl_wr_type  wr,
   input  wire ltb_pkg::srch_req_type req,
   output ltb_pkg::srch_rsp_type     rsp
);
   import ltb_pkg::*;

   logic [POS_W-1:0] mem [LINE_LIMIT];
   logic [POS_W-1:0] rd_data_ff;
   logic [IDX_W-1:0] rd_addr;

   srch_state_type   state_ff, state_in;
   logic [IDX_W-1:0] lo_ff, lo_in;
   logic [CNT_W-1:0] hi_ff, hi_in;
   logic [IDX_W-1:0] mid_ff, mid_in;
   logic [15:0]      off_ff, off_in;
   logic [CNT_W-1:0] span;

   // writes happen only while the text is built, searches only after it:
   // the two never touch the array in the same phase
   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= SR_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      lo_ff  <= lo_in;
      hi_ff  <= hi_in;
      mid_ff <= mid_in;
      off_ff <= off_in;
   end

   assign span = hi_ff - {1'b0, lo_ff};

   always_comb begin
      state_in      = state_ff;
      lo_in         = lo_ff;
      hi_in         = hi_ff;
      mid_in        = mid_ff;
      off_in        = off_ff;
      rd_addr       = lo_ff;
      rsp.valid     = 1'b0;
      rsp.index     = lo_ff;
      rsp.start_pos = rd_data_ff;
      case (state_ff)
         SR_IDLE: begin
            if (req.start) begin
               lo_in    = '0;
               hi_in    = req.count;
               off_in   = req.offset;
               state_in = SR_STEP;
            end
         end
         SR_STEP: begin
            if (span > 13'd1) begin
               mid_in   = lo_ff + span[CNT_W-1:1];
               rd_addr  = mid_in;
               state_in = SR_CMP;
            end else begin
               rd_addr  = lo_ff;
               state_in = SR_FIN;
            end
         end
         SR_CMP: begin
            if (rd_data_ff <= {1'b0, off_ff}) begin
               lo_in = mid_ff;
            end else begin
               hi_in = {1'b0, mid_ff};
            end
            state_in = SR_STEP;
         end
         SR_FIN: begin
            rsp.valid = 1'b1;
            state_in  = SR_IDLE;
         end
         default: begin
            state_in = SR_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

FILE: src/line_table_builder_and_lookup.sv
// channel  ports                                   direction  handshake
// request  req_cmd, req_data_byte, req_query_offset in        start && !busy
// result   rsp_kind .. rsp_overflow                 out       rsp_valid, one cycle
//
// A text byte, or an end word giving at most one result, never raises busy; an end
// word giving two line records holds busy in ST_SECOND, where the second one closes.
// A query holds busy through the binary search over the line-start memory, which
// has one write and one read port (one read and compare per step).
// Synchronous reset clears all control state; the memory is not cleared.
// Results cannot be stalled: each sits on the rsp_ ports for exactly one cycle.
`default_nettype none

module line_table_builder_and_lookup (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic [1:0]  req_cmd,
   input  wire logic [7:0]  req_data_byte,
   input  wire logic [15:0] req_query_offset,
   output logic             rsp_valid,
   output logic [1:0]       rsp_kind,
   output logic [16:0]      rsp_line_begin,
   output logic [16:0]      rsp_line_length,
   output logic [16:0]      rsp_full_length,
   output logic [11:0]      rsp_line_index,
   output logic             rsp_last,
   output logic             rsp_overflow
);
   import ltb_pkg::*;

   ltb_state_type    state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [POS_W-1:0] pos_ff, pos_in;
   logic [POS_W-1:0] cls_ff, cls_in;
   logic             pend_ff, pend_in;
   logic             done_ff, done_in;
   logic             ovf_ff, ovf_in;
   logic [POS_W-1:0] sec_end_ff, sec_end_in;
   logic [1:0]       sec_brk_ff, sec_brk_in;

   logic             rsp_valid_ff, rsp_valid_in;
   kind_type         rsp_kind_ff, rsp_kind_in;
   logic [POS_W-1:0] rsp_begin_ff, rsp_begin_in;
   logic [POS_W-1:0] rsp_len_ff, rsp_len_in;
   logic [POS_W-1:0] rsp_full_ff, rsp_full_in;
   logic [IDX_W-1:0] rsp_index_ff, rsp_index_in;
   logic             rsp_last_ff, rsp_last_in;
   logic             rsp_ovf_ff, rsp_ovf_in;

   // line close: shared between the accept cycle and the follow-up cycle
   logic             cl_do;
   logic [POS_W-1:0] cl_end;
   logic [1:0]       cl_brk;
   logic             cl_last;
   logic [POS_W-1:0] cl_len;
   logic [POS_W-1:0] cl_full;
   logic             cl_room;

   logic             accept;
   tbl_wr_type       wr;
   srch_req_type     sreq;
   srch_rsp_type     srsp;

   ltb_store u_store (
      .clock (clock),
      .reset (reset),
      .wr    (wr),
      .req   (sreq),
      .rsp   (srsp)
   );

   assign busy   = (state_ff != ST_IDLE);
   assign accept = start && !busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         pos_ff       <= '0;
         cls_ff       <= '0;
         pend_ff      <= 1'b0;
         done_ff      <= 1'b0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
         rsp_last_ff  <= 1'b0;
         rsp_ovf_ff   <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         pos_ff       <= pos_in;
         cls_ff       <= cls_in;
         pend_ff      <= pend_in;
         done_ff      <= done_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
         rsp_last_ff  <= rsp_last_in;
         rsp_ovf_ff   <= rsp_ovf_in;
      end
   end

   always_ff @(posedge clock) begin
      sec_end_ff   <= sec_end_in;
      sec_brk_ff   <= sec_brk_in;
      rsp_kind_ff  <= rsp_kind_in;
      rsp_begin_ff <= rsp_begin_in;
      rsp_len_ff   <= rsp_len_in;
      rsp_full_ff  <= rsp_full_in;
      rsp_index_ff <= rsp_index_in;
   end

   assign cl_len  = cl_end - cls_ff;
   assign cl_full = cl_len + {15'd0, cl_brk};
   assign cl_room = (count_ff < LINE_LIMIT);

   always_comb begin
      wr.en   = cl_do && cl_room;
      wr.addr = count_ff[IDX_W-1:0];
      wr.data = cls_ff;
   end

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      pos_in       = pos_ff;
      cls_in       = cls_ff;
      pend_in      = pend_ff;
      done_in      = done_ff;
      ovf_in       = ovf_ff;
      sec_end_in   = sec_end_ff;
      sec_brk_in   = sec_brk_ff;
      cl_do        = 1'b0;
      cl_end       = pos_ff;
      cl_brk       = 2'd0;
      cl_last      = 1'b1;
      sreq.start   = 1'b0;
      sreq.count   = count_ff;
      sreq.offset  = req_query_offset;
      rsp_valid_in = 1'b0;
      rsp_kind_in  = KIND_REJECT;
      rsp_begin_in = '0;
      rsp_len_in   = '0;
      rsp_full_in  = '0;
      rsp_index_in = '0;
      rsp_last_in  = rsp_last_ff;
      rsp_ovf_in   = rsp_ovf_ff;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_cmd)
                  CMD_BYTE: begin
                     if (done_ff || pos_ff >= TEXT_LIMIT) begin
                        rsp_valid_in = 1'b1;
                     end else begin
                        pos_in = pos_ff + 17'd1;
                        if (pend_ff) begin
                           pend_in = 1'b0;
                           cl_do   = 1'b1;
                           cl_end  = pos_ff - 17'd1;
                           if (req_data_byte == CH_LF) begin
                              cl_brk = 2'd2;
                           end else begin
                              cl_brk = 2'd1;
                              if (req_data_byte == CH_LF) begin
                                 cl_last = 1'b0;
                              end
                              if (req_data_byte == CH_CR) begin
                                 pend_in = 1'b1;
                              end
                           end
                        end else if (req_data_byte == CH_LF) begin
                           cl_do  = 1'b1;
                           cl_end = pos_ff;
                           cl_brk = 2'd1;
                        end else if (req_data_byte == CH_CR) begin
                           pend_in = 1'b1;
                        end
                     end
                  end
                  CMD_END: begin
                     if (done_ff) begin
                        rsp_valid_in = 1'b1;
                     end else begin
                        done_in = 1'b1;
                        cl_do   = 1'b1;
                        if (pend_ff) begin
                           // CR at the very end: its line, then the empty last line
                           pend_in    = 1'b0;
                           cl_end     = pos_ff - 17'd1;
                           cl_brk     = 2'd1;
                           cl_last    = 1'b0;
                           sec_end_in = pos_ff;
                           sec_brk_in = 2'd0;
                        end else begin
                           cl_end = pos_ff;
                           cl_brk = 2'd0;
                        end
                     end
                  end
                  CMD_QUERY: begin
                     if (!done_ff || count_ff == '0) begin
                        rsp_valid_in = 1'b1;
                     end else begin
                        sreq.start = 1'b1;
                        state_in   = ST_QUERY;
                     end
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                  end
               endcase
               if (rsp_valid_in) begin
                  rsp_last_in = 1'b1;
               end
               // a text byte closes at most one line (CR LF gives one record with a two-byte break)
               if (req_cmd == CMD_BYTE && cl_do && !cl_last) begin
                  sec_end_in = pos_ff;
                  sec_brk_in = 2'd1;
               end
               if (cl_do && !cl_last) begin
                  state_in = ST_SECOND;
               end
            end
         end
         ST_SECOND: begin
            cl_do    = 1'b1;
            cl_end   = sec_end_ff;
            cl_brk   = sec_brk_ff;
            cl_last  = 1'b1;
            state_in = ST_IDLE;
         end
         ST_QUERY: begin
            if (srsp.valid) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = KIND_ANSWER;
               rsp_begin_in = srsp.start_pos;
               rsp_index_in = srsp.index;
               rsp_last_in  = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (cl_do) begin
         if (cl_room) begin
            count_in = count_ff + 13'd1;
         end else begin
            ovf_in = 1'b1;
         end
         cls_in       = cl_end + {15'd0, cl_brk};
         rsp_valid_in = 1'b1;
         rsp_kind_in  = KIND_RECORD;
         rsp_begin_in = cls_ff;
         rsp_len_in   = cl_len;
         rsp_full_in  = cl_full;
         rsp_index_in = '0;
         rsp_last_in  = cl_last;
      end
      if (rsp_valid_in) begin
         rsp_ovf_in = ovf_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_kind        = rsp_kind_ff;
   assign rsp_line_begin  = rsp_begin_ff;
   assign rsp_line_length = rsp_len_ff;
   assign rsp_full_length = rsp_full_ff;
   assign rsp_line_index  = rsp_index_ff;
   assign rsp_last        = rsp_last_ff;
   assign rsp_overflow    = rsp_ovf_ff;

endmodule

`default_nettype wire

FILE: src/ltb_checker.sv
`default_nettype none

module ltb_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        start,
   input wire logic        busy,
   input wire logic [1:0]  req_cmd,
   input wire logic        rsp_valid,
   input wire logic [1:0]  rsp_kind,
   input wire logic [16:0] rsp_line_length,
   input wire logic [16:0] rsp_full_length,
   input wire logic        rsp_last,
   input wire logic        rsp_overflow
);
   import ltb_pkg::*;

   // an unknown command word is answered at once with a reject
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_cmd == CMD_UNUSED) |=>
         (rsp_valid && rsp_kind == KIND_REJECT && rsp_last))
      else $error("unknown command not rejected");

   // a record that is not the last one is followed straight away by another
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_last) |=> (rsp_valid && rsp_kind == KIND_RECORD))
      else $error("second record missing");

   // table overflow never clears short of reset
   assert property (@(posedge clock) disable iff (reset)
      rsp_overflow |=> rsp_overflow)
      else $error("overflow flag dropped");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_kind != KIND_RECORD) |->
         (rsp_line_length == '0 && rsp_full_length == '0 && rsp_last))
      else $error("answer or reject carries lengths");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_kind == KIND_RECORD) |->
         (rsp_full_length - rsp_line_length <= 17'd2))
      else $error("line break longer than two");

endmodule

bind line_table_builder_and_lookup ltb_checker u_ltb_checker (
   .clock           (clock),
   .reset           (reset),
   .start           (start),
   .busy            (busy),
   .req_cmd         (req_cmd),
   .rsp_valid       (rsp_valid),
   .rsp_kind        (rsp_kind),
   .rsp_line_length (rsp_line_length),
   .rsp_full_length (rsp_full_length),
   .rsp_last        (rsp_last),
   .rsp_overflow    (rsp_overflow)
);

`default_nettype wire

FILE: test/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
   import ltb_pkg::*;

   localparam int QUIET_LIMIT = 3000;
   localparam int MAX_REPORTS = 10;

   typedef struct packed {
      kind_type    kind;
      logic [16:0] first;
      logic [16:0] len;
      logic [16:0] full;
      logic [11:0] index;
      logic        last;
      logic        ovf;
   } line_word_type;

   typedef struct {
      logic [1:0]    cmd;
      logic [7:0]    data;
      logic [15:0]   off;
      logic          typed;
      line_word_type word;
   } stim_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [1:0]  req_cmd = CMD_BYTE;
   logic [7:0]  req_data_byte = '0;
   logic [15:0] req_query_offset = '0;
   logic        rsp_valid;
   logic [1:0]  rsp_kind;
   logic [16:0] rsp_line_begin;
   logic [16:0] rsp_line_length;
   logic [16:0] rsp_full_length;
   logic [11:0] rsp_line_index;
   logic        rsp_last;
   logic        rsp_overflow;

   // typed expectation travels with the request word
   logic          row_typed = 1'b0;
   line_word_type row_word = '0;

   line_table_builder_and_lookup u_top (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_cmd          (req_cmd),
      .req_data_byte    (req_data_byte),
      .req_query_offset (req_query_offset),
      .rsp_valid        (rsp_valid),
      .rsp_kind         (rsp_kind),
      .rsp_line_begin   (rsp_line_begin),
      .rsp_line_length  (rsp_line_length),
      .rsp_full_length  (rsp_full_length),
      .rsp_line_index   (rsp_line_index),
      .rsp_last         (rsp_last),
      .rsp_overflow     (rsp_overflow)
   );

   always #1 clock = ~clock;

   // ---------------- line splitter / lookup predictor ----------------
   logic [16:0]   line_begins [0:4095];
   logic [12:0]   n_lines = '0;
   logic [16:0]   text_pos = '0;
   logic [16:0]   line_first = '0;
   logic          cr_held = 1'b0;
   logic          text_closed = 1'b0;
   logic          tbl_ovf = 1'b0;
   line_word_type fresh_words[$];
   line_word_type due_words[$];

   int n_errors = 0;
   int quiet_cycles = 0;

   task automatic close_line(input logic [16:0] end_pos, input logic [1:0] brk);
      logic [16:0] len;
      len = end_pos - line_first;
      if (n_lines < LINE_LIMIT) begin
         line_begins[n_lines[11:0]] = line_first;
         n_lines = n_lines + 13'd1;
      end else begin
         tbl_ovf = 1'b1;
      end
      fresh_words.push_back('{KIND_RECORD, line_first, len, len + 17'(brk), 12'd0, 1'b0,
                              tbl_ovf});
      line_first = end_pos + 17'(brk);
   endtask

   task automatic split_and_lookup(input logic [1:0] c, input logic [7:0] b,
                                   input logic [15:0] off);
      logic [12:0]   lo, hi, mid;
      line_word_type rej;
      rej = '{KIND_REJECT, 17'd0, 17'd0, 17'd0, 12'd0, 1'b0, 1'b0};
      fresh_words.delete();
      case (c)
         CMD_BYTE: begin
            if (text_closed || text_pos >= TEXT_LIMIT) begin
               rej.ovf = tbl_ovf;
               fresh_words.push_back(rej);
            end else begin
               if (cr_held && b == CH_LF) begin
                  cr_held = 1'b0;
                  close_line(text_pos - 17'd1, 2'd2);
               end else begin
                  if (cr_held) begin
                     cr_held = 1'b0;
                     close_line(text_pos - 17'd1, 2'd1);
                  end
                  if (b == CH_LF) close_line(text_pos, 2'd1);
                  else if (b == CH_CR) cr_held = 1'b1;
               end
               text_pos = text_pos + 17'd1;
            end
         end
         CMD_END: begin
            if (text_closed) begin
               rej.ovf = tbl_ovf;
               fresh_words.push_back(rej);
            end else begin
               if (cr_held) begin
                  cr_held = 1'b0;
                  close_line(text_pos - 17'd1, 2'd1);
               end
               close_line(text_pos, 2'd0);
               text_closed = 1'b1;
            end
         end
         CMD_QUERY: begin
            if (!text_closed || n_lines == 13'd0) begin
               rej.ovf = tbl_ovf;
               fresh_words.push_back(rej);
            end else begin
               lo = '0;
               hi = n_lines;
               while (hi - lo > 13'd1) begin
                  mid = lo + (hi - lo) / 13'd2;
                  if (line_begins[mid[11:0]] <= {1'b0, off}) lo = mid;
                  else hi = mid;
               end
               fresh_words.push_back('{KIND_ANSWER, line_begins[lo[11:0]], 17'd0, 17'd0,
                                       lo[11:0], 1'b0, tbl_ovf});
            end
         end
         default: begin
            rej.ovf = tbl_ovf;
            fresh_words.push_back(rej);
         end
      endcase
      if (fresh_words.size() > 0) fresh_words[fresh_words.size() - 1].last = 1'b1;
   endtask

   // ---------------- acceptance, prediction and checking ----------------
   always @(posedge clock) begin
      line_word_type got, want;
      logic          took;
      took = 1'b0;
      if (!reset) begin
         if (start && busy === 1'b0) begin
            took = 1'b1;
            split_and_lookup(req_cmd, req_data_byte, req_query_offset);
            if (row_typed) due_words.push_back(row_word);
            else foreach (fresh_words[i]) due_words.push_back(fresh_words[i]);
         end
         if (rsp_valid === 1'b1) begin
            took = 1'b1;
            got = '{kind_type'(rsp_kind), rsp_line_begin, rsp_line_length, rsp_full_length,
                    rsp_line_index, rsp_last, rsp_overflow};
            if (due_words.size() == 0) begin
               n_errors++;
               if (n_errors <= MAX_REPORTS)
                  $display("unexpected word: kind %0d begin %0d len %0d full %0d idx %0d",
                           got.kind, got.first, got.len, got.full, got.index);
            end else begin
               want = due_words.pop_front();
               if (got.kind !== want.kind || got.first !== want.first ||
                   got.len !== want.len || got.full !== want.full ||
                   got.index !== want.index || got.last !== want.last ||
                   got.ovf !== want.ovf) begin
                  n_errors++;
                  if (n_errors <= MAX_REPORTS)
                     $display("mismatch exp k%0d b%0d l%0d f%0d i%0d la%0d o%0d %s",
                              want.kind, want.first, want.len, want.full, want.index,
                              want.last, want.ovf,
                              $sformatf("got k%0d b%0d l%0d f%0d i%0d la%0d o%0d",
                                        got.kind, got.first, got.len, got.full,
                                        got.index, got.last, got.ovf));
               end
            end
         end
      end
      quiet_cycles <= took ? 0 : quiet_cycles + 1;
   end

   initial begin
      wait (quiet_cycles >= QUIET_LIMIT);
      $display("== FAIL ==");
      $finish;
   end

   // ---------------- stimulus ----------------
   int idle_pct [4] = '{0, 54, 0, 32};
   int n_sent = 0;

   task automatic send(input logic [1:0] c, input logic [7:0] b, input logic [15:0] off,
                       input logic typed = 1'b0, input line_word_type w = '0);
      int pct;
      pct = idle_pct[(n_sent / 200) % 4];
      while ($urandom_range(99) < pct) begin
         start <= 1'b0;
         req_cmd <= 2'($urandom);
         req_data_byte <= 8'($urandom);
         req_query_offset <= 16'($urandom);
         @(posedge clock);
      end
      start <= 1'b1;
      req_cmd <= c;
      req_data_byte <= b;
      req_query_offset <= off;
      row_typed <= typed;
      row_word <= w;
      do @(posedge clock); while (busy !== 1'b0);
      n_sent++;
   endtask

   // hold the sender off until every outstanding word has come back
   task automatic drain();
      start <= 1'b0;
      @(posedge clock);
      while (due_words.size() != 0) @(posedge clock);
   endtask

   function automatic stim_row_type mk_row(input logic [1:0] c, input logic [7:0] b,
                                           input logic [15:0] off, input logic typed,
                                           input line_word_type w);
      stim_row_type r;
      r.cmd = c;
      r.data = b;
      r.off = off;
      r.typed = typed;
      r.word = w;
      return r;
   endfunction

   function automatic logic [7:0] text_byte();
      int r;
      r = $urandom_range(99);
      if (r < 12) return CH_LF;
      if (r < 20) return CH_CR;
      return 8'($urandom);
   endfunction

   initial begin
      stim_row_type  opening[$];
      stim_row_type  closing[$];
      line_word_type none;
      logic [1:0]    c;
      logic [15:0]   off;
      int            r, k;

      none = '0;
      // before the end of text
      opening.push_back(mk_row(CMD_QUERY, 8'h00, 16'h0000, 1'b1,
                               '{KIND_REJECT, 17'd0, 17'd0, 17'd0, 12'd0, 1'b1, 1'b0}));
      opening.push_back(mk_row(CMD_UNUSED, 8'hFF, 16'hFFFF, 1'b1,
                               '{KIND_REJECT, 17'd0, 17'd0, 17'd0, 12'd0, 1'b1, 1'b0}));
      opening.push_back(mk_row(CMD_QUERY, 8'hFF, 16'hFFFF, 1'b1,
                               '{KIND_REJECT, 17'd0, 17'd0, 17'd0, 12'd0, 1'b1, 1'b0}));
      opening.push_back(mk_row(CMD_BYTE, 8'h61, 16'h0000, 1'b0, none));
      opening.push_back(mk_row(CMD_BYTE, CH_LF, 16'h0000, 1'b1,
                               '{KIND_RECORD, 17'd0, 17'd1, 17'd2, 12'd0, 1'b1, 1'b0}));
      opening.push_back(mk_row(CMD_BYTE, CH_CR, 16'hFFFF, 1'b0, none));
      opening.push_back(mk_row(CMD_BYTE, CH_LF, 16'h0000, 1'b0, none)); // CR LF
      opening.push_back(mk_row(CMD_BYTE, CH_LF, 16'h0000, 1'b0, none)); // empty line
      opening.push_back(mk_row(CMD_BYTE, CH_CR, 16'h0000, 1'b0, none));
      opening.push_back(mk_row(CMD_BYTE, CH_CR, 16'h0000, 1'b0, none)); // CR then CR
      opening.push_back(mk_row(CMD_BYTE, 8'hFF, 16'h0000, 1'b0, none)); // CR then other
      opening.push_back(mk_row(CMD_BYTE, 8'h00, 16'h0000, 1'b0, none));
      opening.push_back(mk_row(CMD_BYTE, CH_CR, 16'h0000, 1'b0, none));
      opening.push_back(mk_row(CMD_BYTE, CH_LF, 16'hFFFF, 1'b0, none));
      opening.push_back(mk_row(CMD_BYTE, 8'h7F, 16'h0000, 1'b0, none));
      // after the end of text
      closing.push_back(mk_row(CMD_BYTE, CH_LF, 16'h0000, 1'b1,
                               '{KIND_REJECT, 17'd0, 17'd0, 17'd0, 12'd0, 1'b1, 1'b0}));
      closing.push_back(mk_row(CMD_END, 8'h00, 16'h0000, 1'b1,
                               '{KIND_REJECT, 17'd0, 17'd0, 17'd0, 12'd0, 1'b1, 1'b0}));
      closing.push_back(mk_row(CMD_QUERY, 8'h00, 16'h0000, 1'b1,
                               '{KIND_ANSWER, 17'd0, 17'd0, 17'd0, 12'd0, 1'b1, 1'b0}));
      closing.push_back(mk_row(CMD_QUERY, 8'hFF, 16'hFFFF, 1'b0, none));
      closing.push_back(mk_row(CMD_QUERY, 8'h00, 16'h0001, 1'b0, none));
      closing.push_back(mk_row(CMD_QUERY, 8'h00, 16'h0002, 1'b0, none));

      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (opening[i])
         send(opening[i].cmd, opening[i].data, opening[i].off, opening[i].typed,
              opening[i].word);

      // random text with a little noise
      for (int i = 0; i < 680; i++) begin
         if (i == 340) drain();
         if ($urandom_range(99) < 3)
            send($urandom_range(1) ? CMD_QUERY : CMD_UNUSED, 8'($urandom), 16'($urandom));
         else
            send(CMD_BYTE, text_byte(), 16'($urandom));
      end

      // last byte leaves a CR pending into the end word
      send(CMD_BYTE, CH_CR, 16'($urandom));
      drain();
      send(CMD_END, 8'($urandom), 16'($urandom));
      drain();

      foreach (closing[i])
         send(closing[i].cmd, closing[i].data, closing[i].off, closing[i].typed,
              closing[i].word);

      for (int i = 0; i < 450; i++) begin
         r = $urandom_range(99);
         if (r < 4) begin
            case ($urandom_range(2))
               0: c = CMD_BYTE;
               1: c = CMD_END;
               default: c = CMD_UNUSED;
            endcase
            send(c, 8'($urandom), 16'($urandom));
         end else begin
            if (r < 45) begin
               k = $urandom_range(int'(n_lines) - 1);
               off = 16'(line_begins[k]) + 16'($urandom_range(2)) - 16'd1;
            end else if (r < 70) begin
               off = 16'($urandom_range(32767));
            end else begin
               off = 16'($urandom);
            end
            send(CMD_QUERY, 8'($urandom), off);
         end
      end

      drain();
      repeat (60) @(posedge clock);
      if (due_words.size() != 0) n_errors++;
      if (n_errors == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
